>>> rtl/tts_pkg.sv
`timescale 1ns / 1ps
package tts_pkg;

  localparam int MAX_ROWS_DEF = 16;
  localparam int DW           = 32;
  localparam int FRAC         = 16;
  localparam int DIV_STEPS    = DW + FRAC;
  localparam int CFG_IDX_W    = 2;

  localparam logic signed [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END   = 2'd1;

  // multiplier operand selects
  localparam logic [1:0] MUL_UP   = 2'd0;
  localparam logic [1:0] MUL_RHS  = 2'd1;
  localparam logic [1:0] MUL_BACK = 2'd2;

  // output value selects
  localparam logic [1:0] OUT_START = 2'd0;
  localparam logic [1:0] OUT_SOL   = 2'd1;
  localparam logic [1:0] OUT_END   = 2'd2;

  typedef struct packed {
    logic       cap_in;
    logic       row0;
    logic       we_piv;
    logic       we_rhs;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       div_start;
    logic       div_back;
    logic       div_first;
    logic       cap_q;
    logic       we_sol;
    logic       load_out;
    logic [1:0] out_sel;
    logic       clr_sing;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

  // saturating difference
  function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] a,
                                                    input logic signed [DW-1:0] b);
    logic signed [DW:0] d;
    begin
      d = {a[DW-1], a} - {b[DW-1], b};
      if (d[DW] != d[DW-1]) return d[DW] ? Q_MIN : Q_MAX;
      return d[DW-1:0];
    end
  endfunction

  // product to q16.16, floor shift then saturate
  function automatic logic signed [DW-1:0] scale_prod(input logic signed [2*DW-1:0] p);
    logic [DW+FRAC-1:0] s;
    begin
      s = p[2*DW-1:FRAC];
      if ((&s[DW+FRAC-1:DW-1]) || !(|s[DW+FRAC-1:DW-1])) return s[DW-1:0];
      return s[DW+FRAC-1] ? Q_MIN : Q_MAX;
    end
  endfunction

endpackage

>>> rtl/tridiagonal_thomas_solver.sv
`timescale 1ns / 1ps
// channel | dir | handshake           | payload
// in_     | in  | in_valid/in_stall   | sub_diag, main_diag, super_diag, rhs, last_row
// out_    | out | out_valid/out_stall | value, last_value, singular
// cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// each later row of a run goes through the 48-step radix-2 divider plus two passes
// of the shared multiplier; the first row of a run is stored without a division.
// back substitution runs each row through the same divider; in emission, each
// solution beat is read from the store before it is loaded, boundary beats directly.
// rows are taken one at a time; in_stall is high while a row or a solve is in work.
// synchronous active-low reset; the stores need no clearing, cfg_ready is always high.
module tridiagonal_thomas_solver #(
  parameter int MAX_ROWS = tts_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [tts_pkg::DW-1:0]     in_sub_diag,
  input  logic signed [tts_pkg::DW-1:0]     in_main_diag,
  input  logic signed [tts_pkg::DW-1:0]     in_super_diag,
  input  logic signed [tts_pkg::DW-1:0]     in_rhs,
  input  logic                              in_last_row,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tts_pkg::DW-1:0]     out_value,
  output logic                              out_last_value,
  output logic                              out_singular,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic signed [tts_pkg::DW-1:0]     cfg_data
);

  localparam int AW = $clog2(MAX_ROWS);

  tts_pkg::cmd_t cmd;
  tts_pkg::sts_t sts;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;

  assign cfg_ready = 1'b1;

  tts_ctrl #(.MAX_ROWS(MAX_ROWS)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_last_row (in_last_row),
    .sts         (sts),
    .cmd         (cmd),
    .raddr       (raddr),
    .waddr       (waddr)
  );

  tts_dp #(.MAX_ROWS(MAX_ROWS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .raddr          (raddr),
    .waddr          (waddr),
    .in_sub_diag    (in_sub_diag),
    .in_main_diag   (in_main_diag),
    .in_super_diag  (in_super_diag),
    .in_rhs         (in_rhs),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_last_value (out_last_value),
    .out_singular   (out_singular)
  );

endmodule

>>> rtl/tts_div.sv
`timescale 1ns / 1ps
module tts_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [tts_pkg::DW-1:0]   num,
  input  logic signed [tts_pkg::DW-1:0]   den,
  output logic                            done,
  output logic signed [tts_pkg::DW-1:0]   quot
);

  localparam int QW = tts_pkg::DIV_STEPS;
  localparam int NW = $clog2(tts_pkg::DIV_STEPS + 1);
  localparam int DW = tts_pkg::DW;

  logic [QW-1:0]  dvd_r;
  logic [DW-1:0]  rem_r;
  logic [DW-1:0]  dvs_r;
  logic           neg_r;
  logic [NW-1:0]  cnt_r;
  logic           busy_r;
  logic           fin_r;
  logic           done_r;
  logic signed [DW-1:0] quot_r;

  logic [DW:0]    rem_sh;
  logic           ge;
  logic [DW:0]    rem_diff;
  logic [DW-1:0]  num_mag;
  logic [DW-1:0]  den_mag;

  // magnitudes and one restoring step
  assign num_mag  = num[DW-1] ? DW'(-num) : num;
  assign den_mag  = den[DW-1] ? DW'(-den) : den;
  assign rem_sh   = {rem_r, dvd_r[QW-1]};
  assign ge       = rem_sh >= {1'b0, dvs_r};
  assign rem_diff = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (start) begin
        if (den == '0) begin
          quot_r <= num[DW-1] ? tts_pkg::Q_MIN : tts_pkg::Q_MAX;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          dvd_r  <= {num_mag, {tts_pkg::FRAC{1'b0}}};
          rem_r  <= '0;
          dvs_r  <= den_mag;
          neg_r  <= num[DW-1] ^ den[DW-1];
          cnt_r  <= NW'(QW);
        end
      end else if (busy_r) begin
        dvd_r <= {dvd_r[QW-2:0], ge};
        rem_r <= ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == NW'(1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        // sign and saturate the quotient
        if (neg_r)
          quot_r <= (dvd_r > QW'({1'b1, {(DW-1){1'b0}}})) ? tts_pkg::Q_MIN
                                                         : DW'(-dvd_r[DW-1:0]);
        else
          quot_r <= (dvd_r > QW'(tts_pkg::Q_MAX)) ? tts_pkg::Q_MAX : dvd_r[DW-1:0];
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

>>> rtl/tts_dp.sv
`timescale 1ns / 1ps
module tts_dp #(
  parameter int MAX_ROWS = tts_pkg::MAX_ROWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tts_pkg::cmd_t                       cmd,
  output tts_pkg::sts_t                       sts,
  input  logic [$clog2(MAX_ROWS)-1:0]         raddr,
  input  logic [$clog2(MAX_ROWS)-1:0]         waddr,
  input  logic signed [tts_pkg::DW-1:0]       in_sub_diag,
  input  logic signed [tts_pkg::DW-1:0]       in_main_diag,
  input  logic signed [tts_pkg::DW-1:0]       in_super_diag,
  input  logic signed [tts_pkg::DW-1:0]       in_rhs,
  input  logic                                cfg_we,
  input  logic [tts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic signed [tts_pkg::DW-1:0]       cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tts_pkg::DW-1:0]       out_value,
  output logic                                out_last_value,
  output logic                                out_singular
);

  localparam int DW = tts_pkg::DW;

  logic signed [DW-1:0] piv_mem [MAX_ROWS];
  logic signed [DW-1:0] rhs_mem [MAX_ROWS];
  logic signed [DW-1:0] up_mem  [MAX_ROWS];
  logic signed [DW-1:0] sol_mem [MAX_ROWS];

  logic signed [DW-1:0] a_r, b_r, c_r, g_r;
  logic signed [DW-1:0] piv_rd_r, rhs_rd_r, up_rd_r, sol_rd_r;
  logic signed [DW-1:0] q_r;
  logic signed [2*DW-1:0] prod_r;
  logic signed [DW-1:0] start_r, end_r;
  logic                 sing_r;
  logic                 ov_r;
  logic signed [DW-1:0] ovalue_r;
  logic                 olast_r, osing_r;

  logic signed [DW-1:0] scaled;
  logic signed [DW-1:0] mul_x, mul_y;
  logic signed [DW-1:0] div_num;
  logic signed [DW-1:0] piv_wd, rhs_wd;
  logic                 div_done;
  logic signed [DW-1:0] div_q;
  logic                 out_free;

  assign scaled = tts_pkg::scale_prod(prod_r);

  // input beat and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 32'sd65536;
      end_r   <= 32'sd131072;
    end else if (cfg_we) begin
      case (cfg_index)
        tts_pkg::CFG_START: start_r <= cfg_data;
        tts_pkg::CFG_END:   end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      a_r <= in_sub_diag;
      b_r <= in_main_diag;
      c_r <= in_super_diag;
      g_r <= in_rhs;
    end
  end

  // row stores, registered reads
  assign piv_wd = cmd.row0 ? b_r : tts_pkg::sat_sub(b_r, scaled);
  assign rhs_wd = cmd.row0 ? g_r : tts_pkg::sat_sub(g_r, scaled);

  always_ff @(posedge clk) begin
    if (cmd.we_piv) piv_mem[waddr] <= piv_wd;
    if (cmd.we_rhs) begin
      rhs_mem[waddr] <= rhs_wd;
      up_mem[waddr]  <= c_r;
    end
    if (cmd.we_sol) sol_mem[waddr] <= div_q;
    piv_rd_r <= piv_mem[raddr];
    rhs_rd_r <= rhs_mem[raddr];
    up_rd_r  <= up_mem[raddr];
    sol_rd_r <= sol_mem[raddr];
  end

  // shared multiplier
  always_comb begin
    case (cmd.mul_sel)
      tts_pkg::MUL_UP:   begin mul_x = q_r;     mul_y = up_rd_r;  end
      tts_pkg::MUL_RHS:  begin mul_x = q_r;     mul_y = rhs_rd_r; end
      tts_pkg::MUL_BACK: begin mul_x = up_rd_r; mul_y = q_r;      end
      default:           begin mul_x = q_r;     mul_y = up_rd_r;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod_r <= mul_x * mul_y;
    if (cmd.cap_q)  q_r    <= div_q;
  end

  // shared divider
  always_comb begin
    if (!cmd.div_back)      div_num = a_r;
    else if (cmd.div_first) div_num = rhs_rd_r;
    else                    div_num = tts_pkg::sat_sub(rhs_rd_r, scaled);
  end

  tts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (piv_rd_r),
    .done  (div_done),
    .quot  (div_q)
  );

  // singular flag
  always_ff @(posedge clk) begin
    if (!rst_n) sing_r <= 1'b0;
    else if (cmd.clr_sing) sing_r <= 1'b0;
    else if (cmd.div_start && piv_rd_r == '0) sing_r <= 1'b1;
  end

  // output register
  assign out_free = !ov_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.load_out) begin
      ov_r    <= 1'b1;
      olast_r <= cmd.out_sel == tts_pkg::OUT_END;
      osing_r <= sing_r;
      case (cmd.out_sel)
        tts_pkg::OUT_START: ovalue_r <= start_r;
        tts_pkg::OUT_SOL:   ovalue_r <= sol_rd_r;
        default:            ovalue_r <= end_r;
      endcase
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  assign sts.div_done    = div_done;
  assign sts.out_free    = out_free;
  assign out_valid       = ov_r;
  assign out_value       = ovalue_r;
  assign out_last_value  = olast_r;
  assign out_singular    = osing_r;

endmodule

>>> rtl/tts_ctrl.sv
`timescale 1ns / 1ps
module tts_ctrl #(
  parameter int MAX_ROWS = tts_pkg::MAX_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_last_row,
  input  tts_pkg::sts_t                 sts,
  output tts_pkg::cmd_t                 cmd,
  output logic [$clog2(MAX_ROWS)-1:0]   raddr,
  output logic [$clog2(MAX_ROWS)-1:0]   waddr
);

  localparam int AW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_ROWS + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ROW0   = 4'd1;
  localparam logic [3:0] S_FDIV   = 4'd2;
  localparam logic [3:0] S_FWAIT  = 4'd3;
  localparam logic [3:0] S_FM1    = 4'd4;
  localparam logic [3:0] S_FM2    = 4'd5;
  localparam logic [3:0] S_FM3    = 4'd6;
  localparam logic [3:0] S_CHK    = 4'd7;
  localparam logic [3:0] S_BRD    = 4'd8;
  localparam logic [3:0] S_BMUL   = 4'd9;
  localparam logic [3:0] S_BDIV   = 4'd10;
  localparam logic [3:0] S_BWAIT  = 4'd11;
  localparam logic [3:0] S_ESTART = 4'd12;
  localparam logic [3:0] S_ERD    = 4'd13;
  localparam logic [3:0] S_ELD    = 4'd14;
  localparam logic [3:0] S_EEND   = 4'd15;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic          last_r, last_nxt;
  logic [CW-1:0] cnt_m1;
  logic          accept;
  logic          first_back;

  assign cnt_m1     = cnt_r - 1'b1;
  assign accept     = in_valid && !in_stall;
  assign in_stall   = state_r != S_IDLE;
  assign first_back = k_r == cnt_m1[AW-1:0];

  // read address follows the phase
  always_comb begin
    case (state_r)
      S_BRD, S_BMUL, S_BDIV, S_BWAIT: raddr = k_r;
      S_ERD, S_ELD:                   raddr = j_r;
      default:                        raddr = cnt_m1[AW-1:0];
    endcase
  end

  assign waddr = (state_r == S_BWAIT) ? k_r : cnt_r[AW-1:0];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    last_nxt  = last_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.cap_in = accept;
        if (accept) begin
          last_nxt  = in_last_row;
          state_nxt = (cnt_r == '0) ? S_ROW0 : S_FDIV;
        end
      end
      S_ROW0: begin
        cmd.row0   = 1'b1;
        cmd.we_piv = 1'b1;
        cmd.we_rhs = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        state_nxt  = S_CHK;
      end
      S_FDIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_FWAIT;
      end
      S_FWAIT: begin
        cmd.cap_q = sts.div_done;
        if (sts.div_done) state_nxt = S_FM1;
      end
      S_FM1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tts_pkg::MUL_UP;
        state_nxt   = S_FM2;
      end
      S_FM2: begin
        cmd.we_piv  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = tts_pkg::MUL_RHS;
        state_nxt   = S_FM3;
      end
      S_FM3: begin
        cmd.we_rhs = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        state_nxt  = S_CHK;
      end
      S_CHK: begin
        k_nxt = cnt_m1[AW-1:0];
        state_nxt = (last_r || cnt_r == CW'(MAX_ROWS)) ? S_BRD : S_IDLE;
      end
      S_BRD: state_nxt = S_BMUL;
      S_BMUL: begin
        cmd.mul_en  = !first_back;
        cmd.mul_sel = tts_pkg::MUL_BACK;
        state_nxt   = S_BDIV;
      end
      S_BDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_back  = 1'b1;
        cmd.div_first = first_back;
        state_nxt     = S_BWAIT;
      end
      S_BWAIT: begin
        cmd.div_back = 1'b1;
        if (sts.div_done) begin
          cmd.cap_q  = 1'b1;
          cmd.we_sol = 1'b1;
          if (k_r == '0) begin
            state_nxt = S_ESTART;
          end else begin
            k_nxt     = k_r - 1'b1;
            state_nxt = S_BRD;
          end
        end
      end
      S_ESTART: begin
        cmd.out_sel = tts_pkg::OUT_START;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          j_nxt        = '0;
          state_nxt    = S_ERD;
        end
      end
      S_ERD: state_nxt = S_ELD;
      S_ELD: begin
        cmd.out_sel = tts_pkg::OUT_SOL;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          if (j_r == cnt_m1[AW-1:0]) begin
            state_nxt = S_EEND;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = S_ERD;
          end
        end
      end
      S_EEND: begin
        cmd.out_sel = tts_pkg::OUT_END;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.clr_sing = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      k_r     <= '0;
      j_r     <= '0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      last_r  <= last_nxt;
    end
  end

`ifndef SYNTHESIS
  // a row is never taken with the store already full
  a_cnt_room: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> cnt_r < CW'(MAX_ROWS))
    else $error("row accepted with full store");

  // results are loaded only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("output overwritten");

  // the end beat closes the run
  a_run_close: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EEND && sts.out_free) |=> (cnt_r == '0 && state_r == S_IDLE))
    else $error("run not closed after end beat");

  // the divider is never restarted while waiting on it
  a_div_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !cmd.div_start)
    else $error("divider restarted");
`endif

endmodule

>>> dv/tridiagonal_thomas_solver_tb.sv
`timescale 1ns / 1ps
module tridiagonal_thomas_solver_tb;

  localparam int DW = tts_pkg::DW;
  localparam int NROWS = tts_pkg::MAX_ROWS_DEF;
  localparam int LIMIT = 3000000;

  typedef struct {
    logic signed [DW-1:0] value;
    logic                 last_value;
    logic                 singular;
  } soln_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [DW-1:0] in_sub_diag = '0;
  logic signed [DW-1:0] in_main_diag = '0;
  logic signed [DW-1:0] in_super_diag = '0;
  logic signed [DW-1:0] in_rhs = '0;
  logic in_last_row = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DW-1:0] out_value;
  logic out_last_value;
  logic out_singular;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic signed [DW-1:0] cfg_data = '0;

  tridiagonal_thomas_solver #(.MAX_ROWS(NROWS)) u_dut (.*);

  always #5 clk = ~clk;

  // solver model state
  logic signed [DW-1:0] piv_q [NROWS];
  logic signed [DW-1:0] rhs_q [NROWS];
  logic signed [DW-1:0] up_q [NROWS];
  int unsigned rows_held;
  bit sing_seen;
  logic signed [DW-1:0] start_val, end_val;

  soln_beat_t expected_beats[$];
  int errors = 0;
  int cycles = 0;
  bit hold_out;

  // q16.16 arithmetic
  function automatic logic signed [DW-1:0] sat64(input longint x);
    if (x > longint'(32'sh7fffffff)) return tts_pkg::Q_MAX;
    if (x < -longint'(64'sd2147483648)) return tts_pkg::Q_MIN;
    return x[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] fx_mul(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat64(p >>> 16);
  endfunction

  function automatic logic signed [DW-1:0] fx_div(input logic signed [DW-1:0] n,
                                                  input logic signed [DW-1:0] d);
    if (d == 0) begin
      sing_seen = 1'b1;
      return (n < 0) ? tts_pkg::Q_MIN : tts_pkg::Q_MAX;
    end
    return sat64((longint'(n) * 65536) / longint'(d));
  endfunction

  function automatic logic signed [DW-1:0] fx_sub(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
    return sat64(longint'(a) - longint'(b));
  endfunction

  // forward elimination, and back substitution at end of system
  function automatic void eliminate_row(input logic signed [DW-1:0] a, b, c, g,
                                        input logic last);
    logic signed [DW-1:0] m;
    logic signed [DW-1:0] sol [NROWS];
    int unsigned i, n;
    soln_beat_t bt;
    i = (rows_held >= NROWS) ? 0 : rows_held;
    if (i == 0) begin
      piv_q[0] = b;
      rhs_q[0] = g;
    end else begin
      m = fx_div(a, piv_q[i-1]);
      piv_q[i] = fx_sub(b, fx_mul(m, up_q[i-1]));
      rhs_q[i] = fx_sub(g, fx_mul(m, rhs_q[i-1]));
    end
    up_q[i] = c;
    n = i + 1;
    rows_held = n;
    if (!last && n < NROWS) return;
    sol[n-1] = fx_div(rhs_q[n-1], piv_q[n-1]);
    for (int k = n - 1; k > 0; k--)
      sol[k-1] = fx_div(fx_sub(rhs_q[k-1], fx_mul(up_q[k-1], sol[k])), piv_q[k-1]);
    bt.singular = sing_seen;
    bt.last_value = 1'b0;
    bt.value = start_val;
    expected_beats.push_back(bt);
    for (int k = 0; k < n; k++) begin
      bt.value = sol[k];
      expected_beats.push_back(bt);
    end
    bt.value = end_val;
    bt.last_value = 1'b1;
    expected_beats.push_back(bt);
    rows_held = 0;
    sing_seen = 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                 input logic [DW-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // send one row beat; valid stays high for a back-to-back follower
  task automatic send_row(input logic signed [DW-1:0] a, b, c, g, input logic last,
                          input bit gaps = 1'b1);
    int wait_n;
    wait_n = gaps ? $urandom_range(0, 5) : 0;
    if (wait_n > 0) begin
      in_valid <= 1'b0;
      repeat (wait_n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sub_diag <= a;
    in_main_diag <= b;
    in_super_diag <= c;
    in_rhs <= g;
    in_last_row <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    eliminate_row(a, b, c, g, last);
  endtask

  task automatic write_reg(input logic [tts_pkg::CFG_IDX_W-1:0] idx,
                           input logic signed [DW-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == tts_pkg::CFG_START) start_val = d;
    else if (idx == tts_pkg::CFG_END) end_val = d;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [DW-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return tts_pkg::Q_MAX;
      1: return tts_pkg::Q_MIN;
      2: return '0;
      3: return $urandom;
      default: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
    endcase
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    soln_beat_t want;
    cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat", out_value, '0);
      end else begin
        want = expected_beats.pop_front();
        if (out_value !== want.value) report_mismatch("value", out_value, want.value);
        if (out_last_value !== want.last_value)
          report_mismatch("last_value", out_last_value, want.last_value);
        if (out_singular !== want.singular)
          report_mismatch("singular", out_singular, want.singular);
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (hold_out) out_stall <= 1'b1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("tridiagonal_thomas_solver_tb: errors");
      $finish;
    end
  end

  // extremes, singular pivots, single-row and full-size systems
  task automatic test_directed();
    send_row('0, 32'sh0001_0000, '0, 32'sh0002_0000, 1'b1);
    send_row(tts_pkg::Q_MIN, 32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b0);
    send_row(32'sh0001_0000, 32'sh0002_0000, tts_pkg::Q_MAX, 32'sh0003_0000, 1'b1);
    send_row('0, '0, tts_pkg::Q_MAX, tts_pkg::Q_MIN, 1'b0);
    send_row(32'sh0001_0000, 32'sh0001_0000, '0, '0, 1'b1);
    send_row(tts_pkg::Q_MAX, tts_pkg::Q_MAX, tts_pkg::Q_MIN, tts_pkg::Q_MAX, 1'b0);
    send_row(tts_pkg::Q_MIN, tts_pkg::Q_MIN, tts_pkg::Q_MAX, tts_pkg::Q_MIN, 1'b1);
    send_row(tts_pkg::Q_MAX, '0, tts_pkg::Q_MIN, -32'sd1, 1'b1);
    // row limit ends the system without last_row
    for (int r = 0; r < NROWS; r++)
      send_row(32'sh0000_8000, 32'sh0004_0000, 32'sh0000_8000, r << 16, 1'b0);
    drain();
  endtask

  task automatic test_config();
    write_reg(tts_pkg::CFG_START, tts_pkg::Q_MAX);
    write_reg(tts_pkg::CFG_END, tts_pkg::Q_MIN);
    send_row('0, 32'sh0003_0000, '0, 32'sh0001_0000, 1'b1);
    drain();
    write_reg(tts_pkg::CFG_START, '0);
    write_reg(tts_pkg::CFG_END, -32'sd1);
    send_row('0, 32'sh0003_0000, '0, 32'sh0001_0000, 1'b1);
    drain();
  endtask

  // random systems, mostly short
  task automatic test_random(input int n_rows);
    int sent;
    int len;
    sent = 0;
    while (sent < n_rows) begin
      len = ($urandom_range(0, 9) == 0) ? NROWS : $urandom_range(1, 5);
      for (int r = 0; r < len; r++) begin
        send_row(rand_word(), rand_word(), rand_word(), rand_word(),
                 (r == len - 1) && ($urandom_range(0, 7) != 0));
        sent++;
      end
      if ($urandom_range(0, 15) == 0) begin
        drain();
        write_reg(tts_pkg::CFG_START, $urandom);
        write_reg(tts_pkg::CFG_END, $urandom);
      end
    end
    drain();
  endtask

  // receiver holds off while rows keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_out = 1'b1;
        repeat (3000) @(posedge clk);
        hold_out = 1'b0;
      end
      for (int r = 0; r < 6; r++)
        send_row(rand_word(), 32'sh0002_0000, rand_word(), rand_word(), 1'(r % 2), 1'b0);
    join
    drain();
  endtask

  initial begin
    hold_out = 1'b0;
    rows_held = 0;
    sing_seen = 1'b0;
    start_val = 32'sh0001_0000;
    end_val = 32'sh0002_0000;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config();
    test_backpressure();
    test_random(470);
    if (errors == 0) $display("tridiagonal_thomas_solver_tb: clean");
    else $display("tridiagonal_thomas_solver_tb: errors");
    $finish;
  end

endmodule

>>> tridiagonal_thomas_solver.f
rtl/tts_pkg.sv
rtl/tts_div.sv
rtl/tts_dp.sv
rtl/tts_ctrl.sv
rtl/tridiagonal_thomas_solver.sv
dv/tridiagonal_thomas_solver_tb.sv
